// ----- design/cts_pkg.sv -----
package cts_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 3;
  localparam int unsigned KindW = 3;

  localparam logic [ModeW-1:0] MODE_IDLE = 3'd0;
  localparam logic [ModeW-1:0] MODE_NAME = 3'd1;
  localparam logic [ModeW-1:0] MODE_OP2  = 3'd2;
  localparam logic [ModeW-1:0] MODE_NUM  = 3'd3;
  localparam logic [ModeW-1:0] MODE_STR  = 3'd4;
  localparam logic [ModeW-1:0] MODE_ESC  = 3'd5;

  localparam logic [KindW-1:0] KIND_NAME     = 3'd0;
  localparam logic [KindW-1:0] KIND_SPECIAL  = 3'd1;
  localparam logic [KindW-1:0] KIND_OPERATOR = 3'd2;
  localparam logic [KindW-1:0] KIND_NUMBER   = 3'd3;
  localparam logic [KindW-1:0] KIND_STRING   = 3'd4;

  localparam logic [ByteW-1:0] END_OF_TEXT = 8'hFF;

  typedef struct packed {
    logic             res_valid;
    logic             res_start;
    logic [KindW-1:0] res_kind;
    logic [ModeW-1:0] mode_nxt;
    logic             quote_dq_nxt;
  } step_t;

endpackage

// ----- design/code_token_splitter_unit.sv -----
// channel  | ports                                          | direction
// ---------+------------------------------------------------+----------
// in       | in_valid, in_ready, in_text_byte               | in
// out      | out_valid, out_ready, out_token_byte/start/kind | out
//
// One byte per cycle sustained while out is not stalled; each byte passes the
// input register, then the result register after the classifier, before its
// result is presented.
// Reset puts the scanner in idle and empties both registers.
// A stall on out holds the result register; the input register then fills
// and in_ready drops until the result beat leaves.
module code_token_splitter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cts_pkg::ByteW-1:0]   in_text_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cts_pkg::ByteW-1:0]   out_token_byte,
  output logic                        out_token_start,
  output logic [cts_pkg::KindW-1:0]   out_token_kind
);

  logic                      in_valid_r;
  logic [cts_pkg::ByteW-1:0] in_byte_r;
  logic [cts_pkg::ModeW-1:0] mode_r;
  logic                      quote_dq_r;
  logic                      out_valid_r;
  logic [cts_pkg::ByteW-1:0] out_byte_r;
  logic                      out_start_r;
  logic [cts_pkg::KindW-1:0] out_kind_r;
  logic                      advance;
  cts_pkg::step_t            step;

  cts_step u_step (
    .text_byte (in_byte_r),
    .mode      (mode_r),
    .quote_dq  (quote_dq_r),
    .step      (step)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mode_r      <= cts_pkg::MODE_IDLE;
      quote_dq_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        mode_r      <= step.mode_nxt;
        quote_dq_r  <= step.quote_dq_nxt;
        out_valid_r <= step.res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_text_byte;
    end
    if (advance) begin
      out_byte_r  <= in_byte_r;
      out_start_r <= step.res_start;
      out_kind_r  <= step.res_kind;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_byte  = out_byte_r;
  assign out_token_start = out_start_r;
  assign out_token_kind  = out_kind_r;

  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_byte_r == cts_pkg::END_OF_TEXT) |=> mode_r == cts_pkg::MODE_IDLE)
    else $error("end of text did not return scanner to idle");

  a_name_mode: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step.res_valid && (step.res_kind == cts_pkg::KIND_NAME)
    |=> mode_r == cts_pkg::MODE_NAME)
    else $error("name byte did not leave scanner in name mode");

  a_cont_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step.res_valid && !step.res_start |-> mode_r != cts_pkg::MODE_IDLE)
    else $error("continuation beat produced from idle");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step.res_valid |=> out_valid_r && (out_byte_r == $past(in_byte_r)))
    else $error("result beat not loaded");

endmodule

// ----- design/cts_step.sv -----
module cts_step (
  input  logic [cts_pkg::ByteW-1:0] text_byte,
  input  logic [cts_pkg::ModeW-1:0] mode,
  input  logic                      quote_dq,
  output cts_pkg::step_t            step
);

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha_first(input logic [7:0] b);
    return (b == 8'h5F) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic punct_char(input logic [7:0] b);
    return (b == 8'h7B) || (b == 8'h7D) || (b == 8'h28) || (b == 8'h29) ||
           (b == 8'h5B) || (b == 8'h5D) || (b == 8'h23) || (b == 8'h2E) ||
           (b == 8'h3B) || (b == 8'h2C);
  endfunction

  function automatic logic op_char(input logic [7:0] b);
    return (b == 8'h2B) || (b == 8'h2D) || (b == 8'h2A) || (b == 8'h2F) ||
           (b == 8'h25) || (b == 8'h21) || (b == 8'h3D) || (b == 8'h26) ||
           (b == 8'h7C) || (b == 8'h5E) || (b == 8'h3E) || (b == 8'h3C);
  endfunction

  function automatic logic is_num_body(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
           ((b >= 8'h41) && (b <= 8'h46)) || (b == 8'h4C) || (b == 8'h78) ||
           (b == 8'h58);
  endfunction

  cts_pkg::step_t fi;
  logic           is_quote;
  logic           close_quote;

  // classify from idle
  always_comb begin
    fi              = '0;
    fi.mode_nxt     = cts_pkg::MODE_IDLE;
    fi.quote_dq_nxt = quote_dq;
    fi.res_start    = 1'b1;
    fi.res_kind     = cts_pkg::KIND_NAME;
    if (is_alpha_first(text_byte)) begin
      fi.res_valid = 1'b1;
      fi.mode_nxt  = cts_pkg::MODE_NAME;
    end else if (punct_char(text_byte)) begin
      fi.res_valid = 1'b1;
      fi.res_kind  = cts_pkg::KIND_SPECIAL;
    end else if (op_char(text_byte)) begin
      fi.res_valid = 1'b1;
      fi.res_kind  = cts_pkg::KIND_OPERATOR;
      fi.mode_nxt  = cts_pkg::MODE_OP2;
    end else if (is_digit(text_byte)) begin
      fi.res_valid = 1'b1;
      fi.res_kind  = cts_pkg::KIND_NUMBER;
      fi.mode_nxt  = cts_pkg::MODE_NUM;
    end else if (is_quote) begin
      fi.res_valid    = 1'b1;
      fi.res_kind     = cts_pkg::KIND_STRING;
      fi.mode_nxt     = cts_pkg::MODE_STR;
      fi.quote_dq_nxt = (text_byte == 8'h22);
    end
  end

  assign is_quote    = (text_byte == 8'h22) || (text_byte == 8'h27);
  assign close_quote = quote_dq ? (text_byte == 8'h22) : (text_byte == 8'h27);

  always_comb begin
    step              = fi;
    if (text_byte == cts_pkg::END_OF_TEXT) begin
      step              = '0;
      step.mode_nxt     = cts_pkg::MODE_IDLE;
      step.quote_dq_nxt = quote_dq;
    end else begin
      case (mode)
        cts_pkg::MODE_NAME: begin
          if (is_alpha_first(text_byte) || is_digit(text_byte)) begin
            step.res_valid = 1'b1;
            step.res_start = 1'b0;
            step.res_kind  = cts_pkg::KIND_NAME;
            step.mode_nxt  = cts_pkg::MODE_NAME;
          end
        end
        cts_pkg::MODE_OP2: begin
          if (op_char(text_byte)) begin
            step.res_valid = 1'b1;
            step.res_start = 1'b0;
            step.res_kind  = cts_pkg::KIND_OPERATOR;
            step.mode_nxt  = cts_pkg::MODE_IDLE;
          end
        end
        cts_pkg::MODE_NUM: begin
          if (is_num_body(text_byte)) begin
            step.res_valid = 1'b1;
            step.res_start = 1'b0;
            step.res_kind  = cts_pkg::KIND_NUMBER;
            step.mode_nxt  = cts_pkg::MODE_NUM;
          end
        end
        cts_pkg::MODE_STR: begin
          step.quote_dq_nxt = quote_dq;
          step.res_start    = 1'b0;
          step.res_kind     = cts_pkg::KIND_STRING;
          if (close_quote) begin
            step.res_valid = 1'b1;
            step.mode_nxt  = cts_pkg::MODE_IDLE;
          end else if (text_byte == 8'h0A) begin
            step.res_valid = 1'b0;
            step.mode_nxt  = cts_pkg::MODE_IDLE;
          end else begin
            step.res_valid = 1'b1;
            step.mode_nxt  = (text_byte == 8'h5C) ? cts_pkg::MODE_ESC : cts_pkg::MODE_STR;
          end
        end
        cts_pkg::MODE_ESC: begin
          step.quote_dq_nxt = quote_dq;
          step.res_valid    = 1'b1;
          step.res_start    = 1'b0;
          step.res_kind     = cts_pkg::KIND_STRING;
          step.mode_nxt     = cts_pkg::MODE_STR;
        end
        default: begin
          step = fi;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb_code_token_splitter_unit.sv -----
module tb_code_token_splitter_unit;
  import cts_pkg::*;

  typedef logic [ByteW-1:0] tbyte_t;

  typedef struct packed {
    tbyte_t           tok_byte;
    logic             tok_start;
    logic [KindW-1:0] tok_kind;
  } token_beat_t;

  localparam tbyte_t DQUOTE  = 8'h22;
  localparam tbyte_t SQUOTE  = 8'h27;
  localparam tbyte_t BSLASH  = 8'h5C;
  localparam tbyte_t NEWLINE = 8'h0A;

  localparam string NAME_FIRST = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string DIGITS     = "0123456789";
  localparam string NUM_BODY   = "0123456789abcdefABCDEFLxX";
  localparam string SPECIALS   = "{}()[]#.;,";
  localparam string OPERATORS  = "+-*/%!=&|^><";
  localparam string BLANKS     = " \t\n\r";

  localparam int TARGET_BYTES = 1300;
  localparam int QUIET_BYTES  = 1150;
  localparam int CYCLE_LIMIT  = 400000;

  class token_tracker;
    logic [ModeW-1:0] scan_mode;
    logic             quote_dq;
    token_beat_t      expected_beats[$];
    int               errors;
    int               n_beats;
    int               n_starts;
    int               n_expected;

    function new();
      scan_mode  = MODE_IDLE;
      quote_dq   = 1'b0;
      errors     = 0;
      n_beats    = 0;
      n_starts   = 0;
      n_expected = 0;
    endfunction

    static function bit in_set(tbyte_t b, string s);
      for (int i = 0; i < s.len(); i++)
        if (b == tbyte_t'(s[i])) return 1'b1;
      return 1'b0;
    endfunction

    static function bit name_lead(tbyte_t b);
      return (b == "_") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    static function bit is_digit(tbyte_t b);
      return b >= "0" && b <= "9";
    endfunction

    function void push_beat(tbyte_t b, logic start, logic [KindW-1:0] kind);
      token_beat_t t;
      t.tok_byte  = b;
      t.tok_start = start;
      t.tok_kind  = kind;
      expected_beats.push_back(t);
      n_expected++;
    endfunction

    function void restart(tbyte_t b);
      scan_mode = MODE_IDLE;
      if (name_lead(b)) begin
        scan_mode = MODE_NAME;
        push_beat(b, 1'b1, KIND_NAME);
      end else if (in_set(b, SPECIALS)) begin
        push_beat(b, 1'b1, KIND_SPECIAL);
      end else if (in_set(b, OPERATORS)) begin
        scan_mode = MODE_OP2;
        push_beat(b, 1'b1, KIND_OPERATOR);
      end else if (is_digit(b)) begin
        scan_mode = MODE_NUM;
        push_beat(b, 1'b1, KIND_NUMBER);
      end else if (b == DQUOTE || b == SQUOTE) begin
        quote_dq  = (b == DQUOTE);
        scan_mode = MODE_STR;
        push_beat(b, 1'b1, KIND_STRING);
      end
    endfunction

    function void take_byte(tbyte_t b);
      if (b == END_OF_TEXT) begin
        scan_mode = MODE_IDLE;
        return;
      end
      case (scan_mode)
        MODE_NAME: begin
          if (name_lead(b) || is_digit(b)) push_beat(b, 1'b0, KIND_NAME);
          else restart(b);
        end
        MODE_OP2: begin
          if (in_set(b, OPERATORS)) begin
            scan_mode = MODE_IDLE;
            push_beat(b, 1'b0, KIND_OPERATOR);
          end else begin
            restart(b);
          end
        end
        MODE_NUM: begin
          if (in_set(b, NUM_BODY)) push_beat(b, 1'b0, KIND_NUMBER);
          else restart(b);
        end
        MODE_STR: begin
          if (b == (quote_dq ? DQUOTE : SQUOTE)) begin
            scan_mode = MODE_IDLE;
            push_beat(b, 1'b0, KIND_STRING);
          end else if (b == NEWLINE) begin
            scan_mode = MODE_IDLE;
          end else begin
            if (b == BSLASH) scan_mode = MODE_ESC;
            push_beat(b, 1'b0, KIND_STRING);
          end
        end
        MODE_ESC: begin
          scan_mode = MODE_STR;
          push_beat(b, 1'b0, KIND_STRING);
        end
        default: restart(b);
      endcase
    endfunction

    task report_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task match_beat(tbyte_t b, logic start, logic [KindW-1:0] kind);
      token_beat_t t;
      if (expected_beats.size() == 0) begin
        report_error($sformatf("unexpected beat byte=%02h start=%0b kind=%0d", b, start, kind));
        return;
      end
      t = expected_beats.pop_front();
      n_beats++;
      if (start) n_starts++;
      if (b !== t.tok_byte)
        report_error($sformatf("token_byte %02h, want %02h", b, t.tok_byte));
      if (start !== t.tok_start)
        report_error($sformatf("token_start %0b, want %0b (byte %02h)", start, t.tok_start,
                               t.tok_byte));
      if (kind !== t.tok_kind)
        report_error($sformatf("token_kind %0d, want %0d (byte %02h)", kind, t.tok_kind,
                               t.tok_byte));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  tbyte_t           in_text_byte;
  logic             out_valid;
  logic             out_ready;
  tbyte_t           out_token_byte;
  logic             out_token_start;
  logic [KindW-1:0] out_token_kind;

  token_tracker sb = new();

  int cycles      = 0;
  int n_sent      = 0;
  int n_directed  = 0;
  int tx_gap_pct  = 10;
  int rx_stall_pct = 10;
  bit quiet       = 1'b0;

  code_token_splitter_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_byte  (out_token_byte),
    .out_token_start (out_token_start),
    .out_token_kind  (out_token_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.match_beat(out_token_byte, out_token_start, out_token_kind);
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic tbyte_t pick(string s);
    return tbyte_t'(s[$urandom_range(0, s.len() - 1)]);
  endfunction

  function automatic int idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 5;
      default: return 30;
    endcase
  endfunction

  task automatic send_byte(tbyte_t b);
    int n;
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      n = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b);
    n_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(tbyte_t'(s[i]));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic send_string();
    tbyte_t q;
    int     n;
    int     r;
    q = $urandom_range(0, 1) ? DQUOTE : SQUOTE;
    send_byte(q);
    n = $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_byte(tbyte_t'($urandom_range(8'h20, 8'h7E)));
      else if (r < 70) begin
        send_byte(BSLASH);
        send_byte(tbyte_t'($urandom_range(0, 255)));
      end else if (r < 80) send_byte(q == DQUOTE ? SQUOTE : DQUOTE);
      else if (r < 90) send_byte(tbyte_t'($urandom_range(8'h80, 8'hFE)));
      else send_byte(tbyte_t'($urandom_range(0, 8'h1F)));
    end
    r = $urandom_range(0, 99);
    if (r < 75) send_byte(q);
    else if (r < 85) send_byte(NEWLINE);
    else if (r < 90) send_byte(END_OF_TEXT);
  endtask

  task automatic send_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      send_byte(pick(NAME_FIRST));
      repeat ($urandom_range(0, 7))
        send_byte($urandom_range(0, 3) == 0 ? pick(DIGITS) : pick(NAME_FIRST));
    end else if (r < 32) begin
      send_byte(pick(DIGITS));
      repeat ($urandom_range(0, 6)) send_byte(pick(NUM_BODY));
    end else if (r < 44) begin
      repeat ($urandom_range(1, 3)) send_byte(pick(OPERATORS));
    end else if (r < 52) begin
      send_byte(pick(SPECIALS));
    end else if (r < 68) begin
      send_string();
    end else if (r < 85) begin
      send_byte(pick(BLANKS));
    end else if (r < 97) begin
      send_byte(tbyte_t'($urandom_range(0, 255)));
    end else begin
      send_byte(END_OF_TEXT);
    end
  endtask

  initial begin
    int  next_phase;
    bit  mid_drained;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = '0;
    next_phase   = 100;
    mid_drained  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("_z9 0xFLg+=<!('a\\''");
    send_byte(DQUOTE);
    send_byte(BSLASH);
    send_byte(NEWLINE);
    send_byte(8'h80);
    send_byte(NEWLINE);
    send_byte(8'hFE);
    send_byte(END_OF_TEXT);
    send_byte(SQUOTE);
    send_byte(BSLASH);
    send_byte(END_OF_TEXT);
    send_byte(8'h00);
    n_directed = n_sent;
    drain();

    while (n_sent < TARGET_BYTES) begin
      if (n_sent >= next_phase) begin
        tx_gap_pct   = idle_pct();
        rx_stall_pct = idle_pct();
        next_phase  += 100;
      end
      if (!mid_drained && n_sent >= TARGET_BYTES / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      if (n_sent >= QUIET_BYTES) quiet = 1'b1;
      send_token();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Run covered %0d text bytes (%0d directed) with %0d token beats checked,",
             n_sent, n_directed, sb.n_beats);
    $display("%0d of them token starts.", sb.n_starts);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cts_pkg.sv
design/cts_step.sv
design/code_token_splitter_unit.sv
sim/tb_code_token_splitter_unit.sv
